[hw/rtl/mdsync_pkg.sv]
`default_nettype none

package mdsync_pkg;

  // Input transaction kinds
  localparam logic [1:0] FUNC_US   = 2'd0;
  localparam logic [1:0] FUNC_MS   = 2'd1;
  localparam logic [1:0] FUNC_MIDI = 2'd2;

  // MIDI real-time bytes
  localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
  localparam logic [7:0] MIDI_START    = 8'hFA;
  localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
  localparam logic [7:0] MIDI_STOP     = 8'hFC;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_PULSE_US   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERNAL_PERIOD_MS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_MS        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS_MS      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BEAT_LED_MS        = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIDI_LED_MS        = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSES_PER_BEAT    = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE_BLINK_MS      = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_DEFAULT_PULSE_US   = 16'd5000;
  localparam logic [7:0]  RST_INTERNAL_PERIOD_MS = 8'd21;
  localparam logic [7:0]  RST_DEBOUNCE_MS        = 8'd50;
  localparam logic [11:0] RST_LONG_PRESS_MS      = 12'd2000;
  localparam logic [7:0]  RST_BEAT_LED_MS        = 8'd30;
  localparam logic [7:0]  RST_MIDI_LED_MS        = 8'd1;
  localparam logic [7:0]  RST_PULSES_PER_BEAT    = 8'd24;
  localparam logic [9:0]  RST_MODE_BLINK_MS      = 10'd500;

  typedef struct packed {
    logic [15:0] default_pulse_us;
    logic [7:0]  internal_period_ms;
    logic [7:0]  debounce_ms;
    logic [11:0] long_press_ms;
    logic [7:0]  beat_led_ms;
    logic [7:0]  midi_led_ms;
    logic [7:0]  pulses_per_beat;
    logic [9:0]  mode_blink_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic       switch_pressed;
  } in_item_t;

  typedef struct packed {
    logic clock_out;
    logic run_out;
    logic led_activity;
    logic led_beat;
    logic mode_internal;
  } out_item_t;

  // Result handoff from the core to the output queue
  typedef struct packed {
    logic      push;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/mdsync_cfg.sv]
`default_nettype none

module mdsync_cfg (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [mdsync_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [mdsync_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output mdsync_pkg::cfg_t                            cfg
);

  // Load defaults on reset, write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_pulse_us   <= mdsync_pkg::RST_DEFAULT_PULSE_US;
      cfg.internal_period_ms <= mdsync_pkg::RST_INTERNAL_PERIOD_MS;
      cfg.debounce_ms        <= mdsync_pkg::RST_DEBOUNCE_MS;
      cfg.long_press_ms      <= mdsync_pkg::RST_LONG_PRESS_MS;
      cfg.beat_led_ms        <= mdsync_pkg::RST_BEAT_LED_MS;
      cfg.midi_led_ms        <= mdsync_pkg::RST_MIDI_LED_MS;
      cfg.pulses_per_beat    <= mdsync_pkg::RST_PULSES_PER_BEAT;
      cfg.mode_blink_ms      <= mdsync_pkg::RST_MODE_BLINK_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdsync_pkg::CFG_DEFAULT_PULSE_US:   cfg.default_pulse_us   <= cfg_data;
        mdsync_pkg::CFG_INTERNAL_PERIOD_MS: cfg.internal_period_ms <= cfg_data[7:0];
        mdsync_pkg::CFG_DEBOUNCE_MS:        cfg.debounce_ms        <= cfg_data[7:0];
        mdsync_pkg::CFG_LONG_PRESS_MS:      cfg.long_press_ms      <= cfg_data[11:0];
        mdsync_pkg::CFG_BEAT_LED_MS:        cfg.beat_led_ms        <= cfg_data[7:0];
        mdsync_pkg::CFG_MIDI_LED_MS:        cfg.midi_led_ms        <= cfg_data[7:0];
        mdsync_pkg::CFG_PULSES_PER_BEAT:    cfg.pulses_per_beat    <= cfg_data[7:0];
        mdsync_pkg::CFG_MODE_BLINK_MS:      cfg.mode_blink_ms      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mdsync_core.sv]
`default_nettype none

module mdsync_core #(
  parameter int TIMER_BITS = 16,
  parameter int HOLD_BITS  = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mdsync_pkg::cfg_t     cfg,
  input  wire logic                 accept,
  input  wire mdsync_pkg::in_item_t item,
  output mdsync_pkg::result_t       result
);

  localparam int LP_BITS = 12;
  localparam int HW = (HOLD_BITS > LP_BITS) ? HOLD_BITS : LP_BITS;
  localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

  logic                  internal_mode, internal_mode_next;
  logic                  running, running_next;
  logic                  clock_level, clock_level_next;
  logic [TIMER_BITS-1:0] itimer, itimer_next;
  logic                  itimer_on, itimer_on_next;
  logic [TIMER_BITS-1:0] pulse_end, pulse_end_next;
  logic [7:0]            beat_count, beat_count_next;
  logic [7:0]            act_count, act_count_next;
  logic [7:0]            beat_led_count, beat_led_count_next;
  logic [7:0]            itick_count, itick_count_next;
  logic [9:0]            blink_count, blink_count_next;
  logic [7:0]            debounce_count, debounce_count_next;
  logic [HOLD_BITS-1:0]  hold_count, hold_count_next;
  logic                  long_done, long_done_next;
  logic                  was_pressed, was_pressed_next;
  logic                  led_act, led_act_next;
  logic                  led_beat, led_beat_next;

  logic                  do_pulse;
  logic [TIMER_BITS-1:0] pulse_width;
  logic [TIMER_BITS-1:0] end_eff;

  // A stored end of zero compares as one
  assign end_eff = (pulse_end == '0) ? TIMER_BITS'(1) : pulse_end;

  // Single-pass state update for one accepted transaction
  always_comb begin
    internal_mode_next  = internal_mode;
    running_next        = running;
    clock_level_next    = clock_level;
    itimer_next         = itimer;
    itimer_on_next      = itimer_on;
    pulse_end_next      = pulse_end;
    beat_count_next     = beat_count;
    act_count_next      = act_count;
    beat_led_count_next = beat_led_count;
    itick_count_next    = itick_count;
    blink_count_next    = blink_count;
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    long_done_next      = long_done;
    was_pressed_next    = was_pressed;
    led_act_next        = led_act;
    led_beat_next       = led_beat;
    do_pulse            = 1'b0;
    pulse_width         = TIMER_BITS'(cfg.default_pulse_us);

    // Decide whether a clock pulse starts
    if (accept) begin
      unique case (item.func)
        mdsync_pkg::FUNC_MS: begin
          if (internal_mode && running) begin
            itick_count_next = itick_count + 8'd1;
            if (itick_count_next >= cfg.internal_period_ms) begin
              itick_count_next = '0;
              do_pulse         = 1'b1;
            end
          end
        end
        mdsync_pkg::FUNC_MIDI: begin
          if (!internal_mode && item.rx_byte == mdsync_pkg::MIDI_CLOCK) begin
            do_pulse = 1'b1;
            if (itimer_on) pulse_width = itimer >> 1;
            act_count_next = cfg.midi_led_ms;
          end
        end
        default: ;
      endcase
    end

    // Raise the clock line, restart the interval timer and advance the beat count
    if (do_pulse) begin
      pulse_end_next   = (pulse_width == '0) ? TIMER_BITS'(1) : pulse_width;
      clock_level_next = 1'b1;
      itimer_next      = '0;
      itimer_on_next   = 1'b1;
      beat_count_next  = beat_count + 8'd1;
      if (beat_count_next == cfg.pulses_per_beat) begin
        beat_count_next     = '0;
        beat_led_count_next = cfg.beat_led_ms;
      end
    end

    if (accept) begin
      unique case (item.func)
        mdsync_pkg::FUNC_US: begin
          // Advance the interval timer, drop the clock at the pulse end
          if (itimer_on) begin
            itimer_next = itimer + TIMER_BITS'(1);
            if (itimer_next == end_eff) clock_level_next = 1'b0;
            if (itimer_next == '0) itimer_on_next = 1'b0;
          end
        end
        mdsync_pkg::FUNC_MS: begin
          // Advance the mode blink
          if (internal_mode && !running) begin
            blink_count_next = blink_count + 10'd1;
            if (blink_count_next >= cfg.mode_blink_ms) blink_count_next = '0;
          end
          // Update LED levels and count down their timers
          if (!internal_mode)
            led_act_next = act_count_next != '0;
          else
            led_act_next = !running && (blink_count_next < (cfg.mode_blink_ms >> 1));
          led_beat_next = running && (beat_led_count_next != '0);
          if (act_count_next != '0) act_count_next = act_count_next - 8'd1;
          if (beat_led_count_next != '0) beat_led_count_next = beat_led_count_next - 8'd1;
          // Debounce the switch, detect short and long presses
          if (item.switch_pressed) begin
            if (!was_pressed) begin
              was_pressed_next    = 1'b1;
              hold_count_next     = '0;
              long_done_next      = 1'b0;
              debounce_count_next = cfg.debounce_ms;
            end else if (debounce_count != '0) begin
              debounce_count_next = debounce_count - 8'd1;
            end else if (!long_done) begin
              if (hold_count != HOLD_MAX) hold_count_next = hold_count + HOLD_BITS'(1);
              if (HW'(hold_count_next) >= HW'(cfg.long_press_ms)) begin
                internal_mode_next = !internal_mode;
                led_act_next       = 1'b1;
                led_beat_next      = 1'b1;
                itick_count_next   = '0;
                blink_count_next   = '0;
                long_done_next     = 1'b1;
              end
            end
          end else begin
            if (was_pressed && !long_done && (HW'(hold_count) < HW'(cfg.long_press_ms))
                && debounce_count == '0) begin
              running_next     = !running;
              itick_count_next = '0;
              if (running_next) begin
                beat_count_next     = '0;
                beat_led_count_next = cfg.beat_led_ms;
              end
            end
            was_pressed_next = 1'b0;
            hold_count_next  = '0;
            long_done_next   = 1'b0;
          end
        end
        mdsync_pkg::FUNC_MIDI: begin
          // Follow start, continue and stop in external mode
          if (!internal_mode) begin
            if (item.rx_byte == mdsync_pkg::MIDI_START ||
                item.rx_byte == mdsync_pkg::MIDI_CONTINUE) begin
              running_next        = 1'b1;
              beat_count_next     = '0;
              beat_led_count_next = cfg.beat_led_ms;
            end else if (item.rx_byte == mdsync_pkg::MIDI_STOP) begin
              running_next = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold state between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      internal_mode  <= 1'b0;
      running        <= 1'b0;
      clock_level    <= 1'b0;
      itimer         <= '0;
      itimer_on      <= 1'b1;
      pulse_end      <= '0;
      beat_count     <= '0;
      act_count      <= '0;
      beat_led_count <= '0;
      itick_count    <= '0;
      blink_count    <= '0;
      debounce_count <= '0;
      hold_count     <= '0;
      long_done      <= 1'b0;
      was_pressed    <= 1'b0;
      led_act        <= 1'b0;
      led_beat       <= 1'b0;
    end else begin
      internal_mode  <= internal_mode_next;
      running        <= running_next;
      clock_level    <= clock_level_next;
      itimer         <= itimer_next;
      itimer_on      <= itimer_on_next;
      pulse_end      <= pulse_end_next;
      beat_count     <= beat_count_next;
      act_count      <= act_count_next;
      beat_led_count <= beat_led_count_next;
      itick_count    <= itick_count_next;
      blink_count    <= blink_count_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      long_done      <= long_done_next;
      was_pressed    <= was_pressed_next;
      led_act        <= led_act_next;
      led_beat       <= led_beat_next;
    end
  end

  // Hand the levels after this transaction to the output queue
  assign result.push               = accept;
  assign result.item.clock_out     = clock_level_next;
  assign result.item.run_out       = running_next;
  assign result.item.led_activity  = led_act_next;
  assign result.item.led_beat      = led_beat_next;
  assign result.item.mode_internal = internal_mode_next;

  a_clock_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(clock_level) |-> $past(accept) && $past(item.func) != mdsync_pkg::FUNC_US)
    else $error("clock line rose without a pulse start");

  a_run_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(running) |-> $past(accept) && ($past(item.func) == mdsync_pkg::FUNC_MS ||
                                         $past(item.func) == mdsync_pkg::FUNC_MIDI))
    else $error("run line rose without a start or a short press");

  a_mode_toggle_long: assert property (@(posedge clk) disable iff (rst)
    (internal_mode != $past(internal_mode)) |-> long_done && was_pressed)
    else $error("mode toggled outside a long press");

endmodule

`default_nettype wire

[hw/rtl/mdsync_outq.sv]
`default_nettype none

module mdsync_outq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mdsync_pkg::result_t result,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mdsync_pkg::out_item_t    out_item
);

  mdsync_pkg::out_item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = count != 2'd0;
  assign full      = count == 2'd2;
  assign out_item  = entry[rd_ptr];

  // Store the result of each accepted transaction
  always_ff @(posedge clk) begin
    if (result.push) entry[wr_ptr] <= result.item;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (result.push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      unique case ({result.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output queue occupancy out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !result.push |=> count == $past(count) - 2'd1)
    else $error("output queue lost track of a pop");

endmodule

`default_nettype wire

[hw/rtl/midi_clock_to_din_sync.sv]
`default_nettype none
// A result is registered into the output queue when its input transaction is accepted.
// Throughput: one transaction per cycle while in_stall is low; the state update is a single pass.
// A two-entry output queue keeps input flowing while a result waits; in_stall
// rises only when both entries are taken by results that are stalled.
// Reset (rst, synchronous, active high) restores every state bit and register
// default and empties the output queue.

module midi_clock_to_din_sync #(
  parameter int TIMER_BITS = 16,
  parameter int HOLD_BITS  = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire mdsync_pkg::in_item_t                   in_item,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output mdsync_pkg::out_item_t                       out_item,
  input  wire logic                                   cfg_we,
  input  wire logic [mdsync_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [mdsync_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  mdsync_pkg::cfg_t    cfg;
  mdsync_pkg::result_t result;
  logic                accept;
  logic                full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  mdsync_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdsync_core #(
    .TIMER_BITS (TIMER_BITS),
    .HOLD_BITS  (HOLD_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (in_item),
    .result (result)
  );

  mdsync_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
